@@ src/imf_pkg.sv @@
`timescale 1ns / 1ps

package imf_pkg;

    // Fixed field widths
    localparam int PIX_W     = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Frame height limit, not tied to storage
    localparam int HEIGHT_LIMIT = 1024;

    // Defaults for top level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_WINDOW = 7;

    // Register reset values
    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 1024;
    localparam int RST_WINDOW = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

    // Input operations
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] FULL_SCALE = '1;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_value;
    } in_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] result_value;
        logic             last;
    } out_beat_t;

    // Link between neighboring sort cells
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             valid;
        logic             gt;
    } link_t;

endpackage

@@ src/imf_sort_cell.sv @@
`timescale 1ns / 1ps

module imf_sort_cell import imf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic             ins,
    input  logic [PIX_W-1:0] din,
    input  link_t            left,
    output link_t            right
);

    logic [PIX_W-1:0] value_reg;
    logic             valid_reg;
    logic             gt;

    // Empty cell counts as larger than anything
    assign gt = !valid_reg || (value_reg > din);

    assign right.value = value_reg;
    assign right.valid = valid_reg;
    assign right.gt    = gt;

    // Insert: take the left neighbor's entry if it moves, else the new value
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            valid_reg <= 1'b0;
        end else if (ins && gt) begin
            if (left.gt) begin
                valid_reg <= left.valid;
            end else begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ins && gt) begin
            if (left.gt) begin
                value_reg <= left.value;
            end else begin
                value_reg <= din;
            end
        end
    end

endmodule

@@ src/imf_sort_chain.sv @@
`timescale 1ns / 1ps

module imf_sort_chain import imf_pkg::*; #(
    parameter int CELLS = DEF_MAX_WINDOW * DEF_MAX_WINDOW
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic             ins,
    input  logic [PIX_W-1:0] din,
    output logic [PIX_W-1:0] median
);

    localparam int MID = (CELLS - 1) / 2;

    link_t links [CELLS+1];

    // Head of the chain never shifts
    assign links[0] = '{value: '0, valid: 1'b0, gt: 1'b0};

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        imf_sort_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clr     (clr),
            .ins     (ins),
            .din     (din),
            .left    (links[i]),
            .right   (links[i+1])
        );
    end

    // Chain is always filled completely, so the median sits in the middle cell
    assign median = links[MID+1].value;

endmodule

@@ src/imf_line_store.sv @@
`timescale 1ns / 1ps

module imf_line_store import imf_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int ROWS      = DEF_MAX_WINDOW + 1
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(ROWS)-1:0]      wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    input  logic [PIX_W-1:0]             wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(ROWS)-1:0]      rd_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    output logic [PIX_W-1:0]             rd_data
);

    logic [PIX_W-1:0] mem [ROWS][MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_slot][wr_col] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_slot][rd_col];
        end
    end

endmodule

@@ src/image_median_filter.sv @@
`timescale 1ns / 1ps

// Streaming median filter: pixels enter in raster order and each result
// leaves in raster order, K rows plus K pixels behind its input, where the
// window side is 2K+1. Border results are full scale. A result that needs
// a median is found by reading the window from the line store one pixel
// per cycle through its single read port into a chain of LMAX*LMAX
// insertion-sort cells, LMAX being the largest odd side not above
// MAX_WINDOW, padded with zeros and full scale values so the median always
// lands in the middle cell. After the last pixel, each further beat, flush
// or pixel, drains one remaining result. A write to the width, height or
// window register restarts the frame. The line store needs no clearing
// after reset.
module image_median_filter import imf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ROWS  = MAX_WINDOW + 1;
    localparam int SW    = $clog2(ROWS);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(HEIGHT_LIMIT + 1);
    localparam int ORW   = $clog2(HEIGHT_LIMIT);
    localparam int LMAX  = MAX_WINDOW - 1 + (MAX_WINDOW % 2);
    localparam int KMAX  = LMAX / 2;
    localparam int KW    = $clog2(KMAX + 1);
    localparam int LW    = KW + 1;
    localparam int CELLS = LMAX * LMAX;
    localparam int FW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
    localparam int DW    = $clog2(KMAX * (MAX_WIDTH + 1) + 1);
    localparam int CMPW  = ((CNTW > DW) ? CNTW : DW) + 1;
    localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_L = (RST_WINDOW > LMAX) ? LMAX : RST_WINDOW;

    // Control states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // Feed kinds into the sort chain
    localparam logic [1:0] FEED_ZERO = 2'd0;
    localparam logic [1:0] FEED_MAX  = 2'd1;
    localparam logic [1:0] FEED_PIX  = 2'd2;

    function automatic logic [KW-1:0] eff_k(input logic [2:0] v);
        int l;
        begin
            l = (v == 3'd0) ? 1 : int'(v);
            if (l > MAX_WINDOW) l = MAX_WINDOW;
            if ((l % 2) == 0) l = l - 1;
            return KW'(l / 2);
        end
    endfunction

    function automatic logic [FW-1:0] pad_of(input logic [KW-1:0] k);
        int l;
        begin
            l = 2 * int'(k) + 1;
            return FW'((CELLS - l * l) / 2);
        end
    endfunction

    // Configuration
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [KW-1:0] k_reg;
    logic [FW-1:0] pad_reg;
    logic [CFG_W-1:0] cfg_v;

    assign cfg_v = (cfg_data == '0) ? CFG_W'(1) : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg   <= WW'(RST_W);
            h_reg   <= HW'(RST_HEIGHT);
            k_reg   <= KW'(RST_L / 2);
            pad_reg <= FW'((CELLS - RST_L * RST_L) / 2);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIDTH: begin
                    w_reg <= (int'(cfg_v) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_v);
                end
                REG_HEIGHT: begin
                    h_reg <= (int'(cfg_v) > HEIGHT_LIMIT) ? HW'(HEIGHT_LIMIT) : HW'(cfg_v);
                end
                REG_WINDOW: begin
                    k_reg   <= eff_k(cfg_data[2:0]);
                    pad_reg <= pad_of(eff_k(cfg_data[2:0]));
                end
                default: begin
                end
            endcase
        end
    end

    logic cfg_restart;
    assign cfg_restart = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                                       || cfg_index == REG_WINDOW);

    // Frame counters
    logic [CW-1:0]   in_col_reg, in_col_next;
    logic [HW-1:0]   in_row_reg, in_row_next;
    logic [SW-1:0]   in_slot_reg, in_slot_next;
    logic [CNTW-1:0] in_cnt_reg, in_cnt_next;
    logic [CW-1:0]   out_col_reg, out_col_next;
    logic [ORW-1:0]  out_row_reg, out_row_next;
    logic [SW-1:0]   out_slot_reg, out_slot_next;

    logic [1:0]      state_reg, state_next;
    logic [FW-1:0]   feed_idx_reg, feed_idx_next;
    logic [SW-1:0]   rd_slot_reg, rd_slot_next;
    logic [CW-1:0]   rd_col_reg, rd_col_next;
    logic [CW-1:0]   rd_base_reg, rd_base_next;
    logic [LW-1:0]   dc_reg, dc_next;
    logic            fd_vld_reg;
    logic [1:0]      fd_kind_reg;
    logic            m_valid_reg, m_valid_next;
    out_beat_t       m_data_reg, m_data_next;

    logic            accept, done, write_px, emit, border, out_free, start_med, advance;
    logic            is_last;
    logic [DW-1:0]   delay;
    logic [1:0]      feed_kind;
    logic            rd_en;
    logic [LW-1:0]   l_side;
    logic [PIX_W-1:0] rd_data, chain_din, median;
    logic [SW:0]     start_slot_ext;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign l_side   = {k_reg, 1'b1};

    assign done     = in_row_reg >= h_reg;
    assign write_px = accept && (s_data.operation == OP_PIXEL) && !done;
    assign delay    = DW'(k_reg) * DW'(w_reg) + DW'(k_reg);
    assign emit     = done ? accept
                    : (write_px && ((CMPW'(in_cnt_reg) + CMPW'(1)) > CMPW'(delay)));

    // Border test on the current output position
    assign border = (out_row_reg < ORW'(k_reg)) || (out_col_reg < CW'(k_reg))
                 || ((HW+1)'(out_row_reg) + (HW+1)'(k_reg) >= (HW+1)'(h_reg))
                 || ((WW+1)'(out_col_reg) + (WW+1)'(k_reg) >= (WW+1)'(w_reg));

    assign is_last = (HW'(out_row_reg) == h_reg - HW'(1))
                  && (WW'(out_col_reg) == w_reg - WW'(1));

    assign start_med = emit && !border;
    assign advance   = (emit && border) || ((state_reg == ST_FIN) && out_free);

    assign start_slot_ext = (SW+1)'(out_slot_reg) + (SW+1)'(ROWS) - (SW+1)'(k_reg);

    // Feed schedule: low pads, high pads, then window pixels
    always_comb begin
        if (feed_idx_reg < pad_reg) begin
            feed_kind = FEED_ZERO;
        end else if ((FW+1)'(feed_idx_reg) < ((FW+1)'(pad_reg) << 1)) begin
            feed_kind = FEED_MAX;
        end else begin
            feed_kind = FEED_PIX;
        end
    end

    assign rd_en = (state_reg == ST_READ) && (feed_kind == FEED_PIX);

    // Next-state logic
    always_comb begin
        state_next    = state_reg;
        feed_idx_next = feed_idx_reg;
        rd_slot_next  = rd_slot_reg;
        rd_col_next   = rd_col_reg;
        rd_base_next  = rd_base_reg;
        dc_next       = dc_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        in_cnt_next   = in_cnt_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        // Input position
        if (write_px) begin
            in_cnt_next = in_cnt_reg + CNTW'(1);
            if (WW'(in_col_reg) == w_reg - WW'(1)) begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + HW'(1);
                in_slot_next = (in_slot_reg == SW'(ROWS - 1)) ? '0 : in_slot_reg + SW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end

        // Sequencer
        case (state_reg)
            ST_IDLE: begin
                if (start_med) begin
                    state_next    = ST_READ;
                    feed_idx_next = '0;
                    dc_next       = '0;
                    if (start_slot_ext >= (SW+1)'(ROWS)) begin
                        rd_slot_next = SW'(start_slot_ext - (SW+1)'(ROWS));
                    end else begin
                        rd_slot_next = SW'(start_slot_ext);
                    end
                    rd_base_next  = out_col_reg - CW'(k_reg);
                    rd_col_next   = out_col_reg - CW'(k_reg);
                end
            end
            ST_READ: begin
                feed_idx_next = feed_idx_reg + FW'(1);
                if (feed_idx_reg == FW'(CELLS - 1)) begin
                    state_next = ST_DRAIN;
                end
                if (rd_en) begin
                    if (dc_reg == l_side - LW'(1)) begin
                        dc_next      = '0;
                        rd_col_next  = rd_base_reg;
                        rd_slot_next = (rd_slot_reg == SW'(ROWS - 1)) ? '0
                                     : rd_slot_reg + SW'(1);
                    end else begin
                        dc_next     = dc_reg + LW'(1);
                        rd_col_next = rd_col_reg + CW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Result and output position
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next.result_value = (state_reg == ST_FIN) ? median : FULL_SCALE;
            m_data_next.last         = is_last;
            if (is_last) begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_slot_next  = '0;
                in_cnt_next   = '0;
                out_col_next  = '0;
                out_row_next  = '0;
                out_slot_next = '0;
            end else if (WW'(out_col_reg) == w_reg - WW'(1)) begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + ORW'(1);
                out_slot_next = (out_slot_reg == SW'(ROWS - 1)) ? '0 : out_slot_reg + SW'(1);
            end else begin
                out_col_next = out_col_reg + CW'(1);
            end
        end

        if (cfg_restart) begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            in_cnt_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_cnt_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            m_valid_reg  <= 1'b0;
            fd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            in_cnt_reg   <= in_cnt_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            m_valid_reg  <= m_valid_next;
            fd_vld_reg   <= (state_reg == ST_READ);
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        feed_idx_reg <= feed_idx_next;
        rd_slot_reg  <= rd_slot_next;
        rd_col_reg   <= rd_col_next;
        rd_base_reg  <= rd_base_next;
        dc_reg       <= dc_next;
        fd_kind_reg  <= feed_kind;
        m_data_reg   <= m_data_next;
    end

    // Chain input lines up with the registered store read
    always_comb begin
        case (fd_kind_reg)
            FEED_ZERO: chain_din = '0;
            FEED_MAX:  chain_din = FULL_SCALE;
            FEED_PIX:  chain_din = rd_data;
            default:   chain_din = rd_data;
        endcase
    end

    imf_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .ROWS      (ROWS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (write_px),
        .wr_slot (in_slot_reg),
        .wr_col  (in_col_reg),
        .wr_data (s_data.pixel_value),
        .rd_en   (rd_en),
        .rd_slot (rd_slot_reg),
        .rd_col  (rd_col_reg),
        .rd_data (rd_data)
    );

    imf_sort_chain #(
        .CELLS (CELLS)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (start_med),
        .ins     (fd_vld_reg),
        .din     (chain_din),
        .median  (median)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_row_reg <= h_reg)
        else $error("input row beyond frame height");

    a_in_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(in_col_reg) < w_reg)
        else $error("input column beyond row width");

    a_out_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(out_col_reg) < w_reg)
        else $error("output column beyond row width");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> !(s_valid && s_ready))
        else $error("beat accepted during median read");
`endif

endmodule

@@ dv/median_scoreboard.sv @@
`timescale 1ns / 1ps

module median_scoreboard import imf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_beat_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_beat_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending_count
);

    localparam int STORE_ROWS = MAX_WINDOW + 1;

    // shadow copy of the block's settings and frame position
    int                 img_w, img_h, win_cfg;
    logic [PIX_W-1:0]   rows_mem [STORE_ROWS*MAX_WIDTH];
    int                 in_col, in_row;
    longint             out_pos;
    out_beat_t          median_q[$];

    assign pending_count = median_q.size();

    function automatic int odd_side();
        int l;
        l = win_cfg;
        if (l == 0) l = 1;
        if (l > MAX_WINDOW) l = MAX_WINDOW;
        if (l % 2 == 0) l--;
        return l;
    endfunction

    function automatic logic [PIX_W-1:0] window_median(int r, int c, int l, int k);
        logic [PIX_W-1:0] vals[$];
        for (int dr = 0; dr < l; dr++)
            for (int dc = 0; dc < l; dc++)
                vals.push_back(rows_mem[((r+dr-k) % STORE_ROWS)*MAX_WIDTH
                                        + ((c+dc-k) % MAX_WIDTH)]);
        vals.sort();
        return vals[(vals.size()-1)/2];
    endfunction

    // compute the next result in raster order
    task automatic push_median(longint total);
        int        l, k, r, c;
        out_beat_t exp_beat;
        l = odd_side();
        k = (l - 1) / 2;
        r = int'(out_pos / img_w);
        c = int'(out_pos % img_w);
        if (r < k || c < k || r + k > img_h - 1 || c + k > img_w - 1)
            exp_beat.result_value = FULL_SCALE;
        else
            exp_beat.result_value = window_median(r, c, l, k);
        exp_beat.last = (out_pos == total - 1);
        median_q.push_back(exp_beat);
        out_pos++;
        if (out_pos >= total) begin
            in_col = 0; in_row = 0; out_pos = 0;
        end
    endtask

    task automatic take_beat(in_beat_t b);
        longint total, delay, cnt;
        int     k;
        total = longint'(img_w) * img_h;
        k = (odd_side() - 1) / 2;
        delay = longint'(k) * img_w + k;
        if (b.operation == OP_PIXEL && in_row < img_h) begin
            rows_mem[(in_row % STORE_ROWS)*MAX_WIDTH + (in_col % MAX_WIDTH)] = b.pixel_value;
            in_col++;
            if (in_col >= img_w) begin
                in_col = 0;
                in_row++;
            end
            cnt = longint'(in_row) * img_w + in_col;
            if (cnt > delay && out_pos < total) push_median(total);
        end else if (in_row >= img_h && out_pos < total) begin
            push_median(total);
        end
    endtask

    always @(posedge aclk) begin
        int        v;
        int        errs;
        out_beat_t exp_beat;
        if (!aresetn) begin
            img_w = RST_WIDTH; img_h = RST_HEIGHT; win_cfg = RST_WINDOW;
            in_col = 0; in_row = 0; out_pos = 0;
            median_q.delete();
            fail_count <= 0;
        end else begin
            errs = 0;
            // register writes restart the frame
            if (cfg_wr_en) begin
                v = cfg_data;
                if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
                    if (v == 0) v = 1;
                    if (cfg_index == REG_WIDTH) img_w = (v > MAX_WIDTH) ? MAX_WIDTH : v;
                    else img_h = (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v;
                    in_col = 0; in_row = 0; out_pos = 0;
                end else if (cfg_index == REG_WINDOW) begin
                    win_cfg = v & 7;
                    in_col = 0; in_row = 0; out_pos = 0;
                end
            end
            if (s_valid && s_ready) take_beat(s_data);
            // compare each result beat with the oldest expectation
            if (m_valid && m_ready) begin
                if (median_q.size() == 0) begin
                    $error("unexpected result beat: result_value %0h last %0b",
                           m_data.result_value, m_data.last);
                    errs++;
                end else begin
                    exp_beat = median_q.pop_front();
                    if (m_data.result_value !== exp_beat.result_value) begin
                        $error("result_value: expected %0h, got %0h",
                               exp_beat.result_value, m_data.result_value);
                        errs++;
                    end
                    if (m_data.last !== exp_beat.last) begin
                        $error("last: expected %0b, got %0b", exp_beat.last, m_data.last);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end

endmodule

@@ dv/tb_image_median_filter.sv @@
`timescale 1ns / 1ps

module tb_image_median_filter;
    import imf_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid, s_ready;
    in_beat_t             s_data;
    logic                 m_valid, m_ready;
    out_beat_t            m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count, pending_count;
    int                   send_idle_pct, recv_stall_pct;
    longint               cycle_count;

    image_median_filter uut (.*);

    median_scoreboard chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_wr_en, .cfg_index, .cfg_data, .fail_count, .pending_count
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // run watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one beat; valid stays high across back-to-back beats
    task automatic send_beat(logic op, logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{operation: op, pixel_value: pix};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // feed a whole frame followed by enough beats to drain the pending results
    task automatic send_frame(int w, int h, int k, int mode);
        logic [PIX_W-1:0] p;
        for (int i = 0; i < w * h; i++) begin
            case (mode)
                0: p = PIX_W'($urandom);
                1: p = ($urandom_range(1) != 0) ? '1 : '0;
                default: p = PIX_W'($urandom_range(7));
            endcase
            send_beat(OP_PIXEL, p);
        end
        for (int i = 0; i < k * w + k + 2; i++)
            send_beat(($urandom_range(3) == 0) ? OP_PIXEL : OP_FLUSH, PIX_W'($urandom));
    endtask

    initial begin
        int w, h, wv, l, k;
        aresetn = 0; s_valid = 0; s_data = '0; cfg_wr_en = 0; cfg_index = REG_WIDTH;
        cfg_data = '0; send_idle_pct = 0; recv_stall_pct = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: early flush, tiny frames, extremes of window and size
        send_beat(OP_FLUSH, '1);
        drain_and_idle();
        write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 0); write_reg(REG_WINDOW, 0);
        send_beat(OP_PIXEL, '1); send_beat(OP_FLUSH, '0); send_beat(OP_PIXEL, 16'h8000);
        drain_and_idle();
        write_reg(REG_WIDTH, 3); write_reg(REG_HEIGHT, 3); write_reg(REG_WINDOW, 3);
        for (int i = 0; i < 9; i++) send_beat(OP_PIXEL, (i % 2) ? 16'hFFFF : 16'h0000);
        send_beat(OP_FLUSH, '0); send_beat(OP_PIXEL, 16'h1234); send_beat(OP_FLUSH, '0);
        drain_and_idle();
        // restart mid-frame with a register write
        write_reg(REG_WINDOW, 6);
        send_beat(OP_PIXEL, 16'd1); send_beat(OP_PIXEL, 16'd2);
        drain_and_idle();
        write_reg(REG_WIDTH, 2047); write_reg(REG_HEIGHT, 1); write_reg(REG_WINDOW, 7);
        send_beat(OP_PIXEL, 16'h5555);
        drain_and_idle();

        // random frames across idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 6 : 50) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 6 : 50) : 0;
            for (int f = 0; f < 5; f++) begin
                w  = (f == 0) ? $urandom_range(7, 12) : $urandom_range(1, 9);
                h  = $urandom_range(1, 8);
                wv = $urandom_range(7);
                l  = (wv == 0) ? 1 : wv;
                if (l % 2 == 0) l--;
                k  = (l - 1) / 2;
                write_reg(REG_WIDTH, w);
                write_reg(REG_HEIGHT, h);
                write_reg(REG_WINDOW, wv);
                send_frame(w, h, k, $urandom_range(2));
                drain_and_idle();
            end
        end
        // a full-width row; the frame is cut short by the next register write
        write_reg(REG_WIDTH, 1024); write_reg(REG_HEIGHT, 1); write_reg(REG_WINDOW, 1);
        for (int i = 0; i < 224; i++) send_beat(OP_PIXEL, PIX_W'($urandom));
        drain_and_idle();
        write_reg(REG_WIDTH, 16); write_reg(REG_HEIGHT, 8); write_reg(REG_WINDOW, 7);
        send_frame(16, 8, 3, 0);
        drain_and_idle();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
